FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while rst_n is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/tcsp_pkg.sv
// ---------------------------------------------------------------------------
// tcsp_pkg
// Types and constants for the three-channel servo pulse generator.
// ---------------------------------------------------------------------------
package tcsp_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CHANNEL_W  = 2;
    localparam int WIDTH_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = SAMPLE_W + WIDTH_W;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = '1;
    localparam logic [WIDTH_W-1:0]  RESET_PERIOD = 16'd20000;
    localparam logic [WIDTH_W-1:0]  RESET_MIN    = 16'd1000;
    localparam logic [WIDTH_W-1:0]  RESET_MAX    = 16'd2000;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 16'd1500;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD = 2'd0,
        REG_MIN    = 2'd1,
        REG_MAX    = 2'd2
    } reg_idx_t;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic [CHANNEL_W-1:0] channel;
    } item_ctrl_t;

    localparam item_ctrl_t CTRL_IDLE = '{valid: 1'b0, op: OP_TICK, channel: '0};

endpackage

FILE: rtl/three_channel_servo_pwm.sv
// ---------------------------------------------------------------------------
// three_channel_servo_pwm
// Servo pulse generator: microsecond ticks advance a frame counter, ADC
// samples set per-channel pulse widths.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per transfer, either a tick (s_op = 0) or a sample
//   (s_op = 1) for channel s_channel; channels at or above NUM_SERVOS are
//   dropped. Every item gives one result on the m_ channel: the line levels
//   after that item, bit i for servo i.
//   cfg_ channel: write period_ticks (0), min_width (1) or max_width (2)
//   while no item is in flight; other indexes are ignored.
//   Throughput is one item per cycle. An item passes one input stage, the
//   sample multiply, the shift-add quotient estimate and its correction;
//   line and width state update in the cycle that loads the result register.
//   Items stay in order, so a sample always takes effect on the next tick
//   behind it.
//   Reset clears the pipeline, sets the counter to 0, all lines low, widths
//   to 1500 and the registers to 20000/1000/2000. While the result is held
//   by the receiver the whole pipeline stalls and s_ready drops.
// ---------------------------------------------------------------------------
module three_channel_servo_pwm #(
    parameter int NUM_SERVOS = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [tcsp_pkg::CHANNEL_W-1:0] s_channel,
    input  logic [tcsp_pkg::SAMPLE_W-1:0]  s_sample,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [NUM_SERVOS-1:0]          m_servo_lines,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcsp_pkg::WIDTH_W-1:0]   cfg_data
);

    localparam int WW = tcsp_pkg::WIDTH_W;

    logic [WW-1:0] period_reg, min_reg, max_reg, diff_reg;
    logic [WW-1:0] diff_next;

    tcsp_pkg::item_ctrl_t          ctrl0_reg, ctrl3;
    logic [tcsp_pkg::SAMPLE_W-1:0] sample0_reg;
    logic [WW-1:0]                 quot3;

    logic [WW-1:0]         counter_reg, counter_next;
    logic [WW-1:0]         width_reg  [NUM_SERVOS];
    logic [WW-1:0]         width_next [NUM_SERVOS];
    logic [NUM_SERVOS-1:0] line_reg, line_next;
    logic                  m_valid_reg, m_valid_next;

    logic          advance;
    logic          retire;
    logic [WW:0]   counter_inc;
    logic [WW-1:0] width_new;

    // whole pipeline moves together when the result slot can take data
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && advance;
    assign cfg_ready = aresetn;

    // ---- configuration ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= tcsp_pkg::RESET_PERIOD;
            min_reg    <= tcsp_pkg::RESET_MIN;
            max_reg    <= tcsp_pkg::RESET_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tcsp_pkg::reg_idx_t'(cfg_index))
                tcsp_pkg::REG_PERIOD: period_reg <= cfg_data;
                tcsp_pkg::REG_MIN:    min_reg    <= cfg_data;
                tcsp_pkg::REG_MAX:    max_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // inverted range clamps the span to zero
    assign diff_next = (max_reg > min_reg) ? max_reg - min_reg : '0;

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
    end

    // ---- input stage ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl0_reg <= tcsp_pkg::CTRL_IDLE;
        end else if (advance) begin
            ctrl0_reg.valid   <= s_valid;
            ctrl0_reg.op      <= tcsp_pkg::op_t'(s_op);
            ctrl0_reg.channel <= s_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sample0_reg <= s_sample;
        end
    end

    tcsp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_ctrl   (ctrl0_reg),
        .in_sample (sample0_reg),
        .diff      (diff_reg),
        .out_ctrl  (ctrl3),
        .out_quot  (quot3)
    );

    // ---- final stage: width write or tick, then load result ----
    assign retire      = ctrl3.valid && advance;
    assign counter_inc = {1'b0, counter_reg} + (WW + 1)'(1);
    assign width_new   = min_reg + quot3;

    always_comb begin
        counter_next = counter_reg;
        line_next    = line_reg;
        width_next   = width_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = ctrl3.valid;
        end
        if (retire) begin
            if (ctrl3.op == tcsp_pkg::OP_SAMPLE) begin
                for (int i = 0; i < NUM_SERVOS; i++) begin
                    if (int'(ctrl3.channel) == i) begin
                        width_next[i] = width_new;
                    end
                end
            end else begin
                // wrap sets every line; a matching width clears it again
                if (counter_inc >= {1'b0, period_reg}) begin
                    counter_next = '0;
                    line_next    = '1;
                end else begin
                    counter_next = counter_inc[WW-1:0];
                end
                for (int i = 0; i < NUM_SERVOS; i++) begin
                    if (counter_next == width_reg[i]) begin
                        line_next[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            line_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SERVOS; i++) begin
                width_reg[i] <= tcsp_pkg::RESET_WIDTH;
            end
        end else begin
            counter_reg <= counter_next;
            line_reg    <= line_next;
            m_valid_reg <= m_valid_next;
            width_reg   <= width_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_servo_lines = line_reg;

endmodule

FILE: rtl/tcsp_scale.sv
// ---------------------------------------------------------------------------
// tcsp_scale
// Three-stage scaler: floor(sample * diff / FULL_SCALE), with item control
// carried alongside. Division by 2^SAMPLE_W-1 uses a shift-add estimate and
// one correction step.
// ---------------------------------------------------------------------------
module tcsp_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  tcsp_pkg::item_ctrl_t          in_ctrl,
    input  logic [tcsp_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [tcsp_pkg::WIDTH_W-1:0]  diff,
    output tcsp_pkg::item_ctrl_t          out_ctrl,
    output logic [tcsp_pkg::WIDTH_W-1:0]  out_quot
);

    localparam int PW  = tcsp_pkg::PROD_W;
    localparam int SW  = tcsp_pkg::SAMPLE_W;
    localparam int EW  = PW + 1;
    localparam int TW  = EW - SW;
    localparam int RW  = PW + 2;

    tcsp_pkg::item_ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic [PW-1:0] prod1_reg, prod2_reg;
    logic [TW-1:0] est2_reg;
    logic [tcsp_pkg::WIDTH_W-1:0] quot3_reg;

    logic [EW-1:0] est_sum;
    logic [TW-1:0] est;
    logic [RW-1:0] rem;
    logic [TW-1:0] quot_full;

    // x/(2^n-1) ~ (x + x>>n + x>>2n) >> n, never above the true quotient
    assign est_sum = EW'(prod1_reg) + EW'(prod1_reg >> SW) + EW'(prod1_reg >> (2 * SW));
    assign est     = est_sum[EW-1:SW];

    // remainder = x - est*(2^n-1); at most one step short
    assign rem = RW'(prod2_reg) + RW'(est2_reg) - (RW'(est2_reg) << SW);
    assign quot_full = (rem >= RW'(tcsp_pkg::FULL_SCALE)) ? est2_reg + TW'(1) : est2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= tcsp_pkg::CTRL_IDLE;
            ctrl2_reg <= tcsp_pkg::CTRL_IDLE;
            ctrl3_reg <= tcsp_pkg::CTRL_IDLE;
        end else if (advance) begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod1_reg <= PW'(in_sample) * PW'(diff);
            prod2_reg <= prod1_reg;
            est2_reg  <= est;
            quot3_reg <= quot_full[tcsp_pkg::WIDTH_W-1:0];
        end
    end

    assign out_ctrl = ctrl3_reg;
    assign out_quot = quot3_reg;

endmodule

FILE: rtl/tcsp_checker.sv
// ---------------------------------------------------------------------------
// tcsp_checker
// Port-level checks for the servo pulse generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcsp_checker #(
    parameter int NUM_SERVOS = 3
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [NUM_SERVOS-1:0] m_servo_lines
);

    logic in_xfer;

    assign in_xfer = s_valid && s_ready;

    // reset empties the result slot
    `ASSERT_NEXT(a_reset_empties, aclk, 1'b1, !aresetn, !m_valid)

    // a held result keeps its line levels
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_servo_lines))

    // an empty result slot never blocks the input
    `ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // with no stall, a transfer always shows up as a result
    `ASSERT_NEXT(a_latency, aclk, aresetn, in_xfer ##1 m_ready [*4], m_valid)

endmodule

bind three_channel_servo_pwm tcsp_checker #(.NUM_SERVOS(NUM_SERVOS)) u_tcsp_checker (.*);

FILE: bench/three_channel_servo_pwm_tb.sv
// ----------------------------------------------------------------------------
// three_channel_servo_pwm_tb
// Checks the servo pulse generator against a cycle-free predictor of the frame
// counter, pulse widths and line levels. Directed items cover the sample
// scaling limits, an inverted width range, wrap with zero width and a period
// dropped below the running count. Random ticks and samples then run under
// several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module three_channel_servo_pwm_tb;

    localparam int SERVO_COUNT = 3;
    localparam logic [tcsp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_op = 1'b0;
    logic [tcsp_pkg::CHANNEL_W-1:0] s_channel = '0;
    logic [tcsp_pkg::SAMPLE_W-1:0]  s_sample = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [SERVO_COUNT-1:0]         m_servo_lines;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tcsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tcsp_pkg::WIDTH_W-1:0]   cfg_data = '0;

    // predictor state
    logic [tcsp_pkg::WIDTH_W-1:0] period_reg;
    logic [tcsp_pkg::WIDTH_W-1:0] min_reg;
    logic [tcsp_pkg::WIDTH_W-1:0] max_reg;
    logic [tcsp_pkg::WIDTH_W-1:0] frame_count;
    logic [tcsp_pkg::WIDTH_W-1:0] width_of [SERVO_COUNT];
    logic [SERVO_COUNT-1:0]       line_state;

    logic [SERVO_COUNT-1:0] pending_lines [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    three_channel_servo_pwm #(.NUM_SERVOS(SERVO_COUNT)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_servo_lines (m_servo_lines),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_lines
        logic [SERVO_COUNT-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lines.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %b",
                         $time, m_servo_lines);
                error_count++;
            end else begin
                want = pending_lines.pop_front();
                if (m_servo_lines !== want) begin
                    $display("%0t: servo_lines mismatch, expected %b, got %b",
                             $time, want, m_servo_lines);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [tcsp_pkg::WIDTH_W-1:0] sample_to_width(
            logic [tcsp_pkg::SAMPLE_W-1:0] smp);
        logic [31:0] span_range;
        logic [31:0] span;
        span_range = (max_reg > min_reg) ? 32'(max_reg - min_reg) : 32'd0;
        span = (32'(smp) * span_range) / 32'(tcsp_pkg::FULL_SCALE);
        return tcsp_pkg::WIDTH_W'(32'(min_reg) + span);
    endfunction

    // Apply one item to the predictor and return the line levels after it.
    function automatic logic [SERVO_COUNT-1:0] next_line_levels(tcsp_pkg::op_t op,
            logic [tcsp_pkg::CHANNEL_W-1:0] ch, logic [tcsp_pkg::SAMPLE_W-1:0] smp);
        logic [tcsp_pkg::WIDTH_W:0] advanced;
        if (op == tcsp_pkg::OP_SAMPLE) begin
            if (ch < SERVO_COUNT)
                width_of[ch] = sample_to_width(smp);
        end else begin
            advanced = {1'b0, frame_count} + (tcsp_pkg::WIDTH_W + 1)'(1);
            if (advanced >= {1'b0, period_reg}) begin
                frame_count = '0;
                line_state = '1;
            end else begin
                frame_count = advanced[tcsp_pkg::WIDTH_W-1:0];
            end
            // clear after set: a zero width keeps its line low on wrap
            for (int i = 0; i < SERVO_COUNT; i++)
                if (frame_count == width_of[i])
                    line_state[i] = 1'b0;
        end
        return line_state;
    endfunction

    task automatic send_item(input tcsp_pkg::op_t op,
                             input logic [tcsp_pkg::CHANNEL_W-1:0] ch,
                             input logic [tcsp_pkg::SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_channel <= ch;
        s_sample  <= smp;
        do @(posedge aclk); while (!s_ready);
        pending_lines.push_back(next_line_levels(op, ch, smp));
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(tcsp_pkg::OP_TICK, tcsp_pkg::CHANNEL_W'($urandom),
                      tcsp_pkg::SAMPLE_W'($urandom));
    endtask

    // Drop valid and hold until every outstanding result has arrived.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tcsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcsp_pkg::WIDTH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tcsp_pkg::REG_PERIOD: period_reg = val;
            tcsp_pkg::REG_MIN:    min_reg = val;
            tcsp_pkg::REG_MAX:    max_reg = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [tcsp_pkg::WIDTH_W-1:0] period,
                                input logic [tcsp_pkg::WIDTH_W-1:0] minw,
                                input logic [tcsp_pkg::WIDTH_W-1:0] maxw);
        write_reg(tcsp_pkg::REG_PERIOD, period);
        write_reg(tcsp_pkg::REG_MIN, minw);
        write_reg(tcsp_pkg::REG_MAX, maxw);
        write_reg(REG_UNUSED, tcsp_pkg::WIDTH_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_ticks(2);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd3, 12'hfff);
        send_ticks(1);
    endtask

    task automatic test_scale_extremes();
        wait_idle();
        program_regs(16'd2, 16'd0, 16'hffff);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd0, 12'hfff);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd1, 12'h000);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd2, 12'h800);
        send_ticks(4);
    endtask

    task automatic test_inverted_range();
        wait_idle();
        program_regs(16'd3, 16'hffff, 16'd0);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd0, 12'd1234);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd2, 12'hfff);
        send_ticks(3);
    endtask

    task automatic test_period_drop();
        wait_idle();
        program_regs(16'hffff, 16'd4, 16'd40);
        send_item(tcsp_pkg::OP_SAMPLE, 2'd1, 12'hfff);
        send_ticks(6);
        wait_idle();
        // count now sits above the new period, so the next tick wraps
        program_regs(16'd3, 16'd4, 16'd40);
        send_ticks(3);
    endtask

    task automatic test_random_traffic();
        logic [tcsp_pkg::WIDTH_W-1:0] period;
        logic [tcsp_pkg::WIDTH_W-1:0] minw;
        logic [tcsp_pkg::WIDTH_W-1:0] maxw;
        logic [tcsp_pkg::SAMPLE_W-1:0] smp;
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int setting = 0; setting < 5; setting++) begin
                wait_idle();
                if ($urandom_range(5) == 0) begin
                    period = tcsp_pkg::WIDTH_W'($urandom_range(65535, 2));
                    minw = $urandom_range(1) ? 16'hffff : 16'd0;
                    maxw = $urandom_range(1) ? 16'hffff : 16'd0;
                end else begin
                    // short frames so lines wrap and clear many times
                    period = tcsp_pkg::WIDTH_W'($urandom_range(48, 2));
                    minw = tcsp_pkg::WIDTH_W'($urandom_range(period + 4, 0));
                    maxw = tcsp_pkg::WIDTH_W'($urandom_range(period + 12, 0));
                end
                program_regs(period, minw, maxw);
                repeat (55) begin
                    if ($urandom_range(99) < 70) begin
                        send_ticks(1);
                    end else begin
                        pick = $urandom_range(7);
                        smp = (pick == 0) ? 12'h000 :
                              (pick == 1) ? 12'hfff : tcsp_pkg::SAMPLE_W'($urandom);
                        send_item(tcsp_pkg::OP_SAMPLE,
                                  tcsp_pkg::CHANNEL_W'($urandom_range(3)), smp);
                    end
                end
            end
        end
    endtask

    initial begin
        period_reg  = tcsp_pkg::RESET_PERIOD;
        min_reg     = tcsp_pkg::RESET_MIN;
        max_reg     = tcsp_pkg::RESET_MAX;
        frame_count = '0;
        line_state  = '0;
        for (int i = 0; i < SERVO_COUNT; i++)
            width_of[i] = tcsp_pkg::RESET_WIDTH;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_scale_extremes();
        test_inverted_range();
        test_period_drop();
        test_random_traffic();

        recv_stall_pct = 0;
        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_lines.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
